### rtl/core/aoxrt_pkg.sv
// Shared constants and types for the alternating OR/XOR reduction tree.
package aoxrt_pkg;

    // Tree depth and stored word width.
    localparam int LEVELS      = 10;
    localparam int VALUE_WIDTH = 32;

    // Fixed widths of the port fields.
    localparam int INDEX_W = 10;
    localparam int ROOT_W  = 32;

    // Number of leaves; also the number of addresses the clearing pass walks.
    localparam int LEAF_COUNT = 1 << LEVELS;

    typedef logic [LEVELS-1:0]      t_idx;
    typedef logic [VALUE_WIDTH-1:0] t_value;

    // One word handed from a cell to the next one up the tree.
    typedef struct packed {
        logic   valid;
        t_idx   idx;
        t_value value;
    } t_hop;

endpackage

### rtl/core/aoxrt_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module aoxrt_ram #(
    parameter int ADDR_W = 1,
    parameter int DATA_W = 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/aoxrt_cell.sv
// One tree level: combines the updated node with its sibling and hands the parent up.
module aoxrt_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_is_or,
    input  aoxrt_pkg::t_hop      i_hop,
    input  aoxrt_pkg::t_value    i_sibling,
    output aoxrt_pkg::t_hop      o_hop
);

    logic                r_valid;
    aoxrt_pkg::t_idx     r_idx;
    aoxrt_pkg::t_value   r_value;
    aoxrt_pkg::t_value   n_value;

    // Parent value: OR at odd heights, XOR at even heights.
    always_comb begin
        if (i_is_or) begin
            n_value = i_hop.value | i_sibling;
        end else begin
            n_value = i_hop.value ^ i_sibling;
        end
    end

    // Valid flag travels with the word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_hop.valid;
        end
    end

    // The parent's index is the child's index shifted down by one.
    always_ff @(posedge i_clk) begin
        if (i_hop.valid) begin
            r_idx   <= i_hop.idx >> 1;
            r_value <= n_value;
        end
    end

    assign o_hop.valid = r_valid;
    assign o_hop.idx   = r_idx;
    assign o_hop.value = r_value;

endmodule

### rtl/core/alternating_or_xor_reduction_tree.sv
// Top level: point-update OR/XOR reduction tree as a chain of per-level cells.
// Path: input register, one cell per level, then the two-entry output queue.
// A new word is taken only once the last one has left the cell chain and the output
// has room; the chain walks one tree level per cycle and holds one update at a time.
// Reset: a clearing pass zeroes every level memory, with o_ready low until it ends;
// two results can wait at the output.
module alternating_or_xor_reduction_tree (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [aoxrt_pkg::INDEX_W-1:0]   i_leaf_index,
    input  logic [aoxrt_pkg::ROOT_W-1:0]    i_leaf_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [aoxrt_pkg::ROOT_W-1:0]    o_root_value
);

    localparam int LEVELS = aoxrt_pkg::LEVELS;

    aoxrt_pkg::t_hop   hop     [0:LEVELS];
    aoxrt_pkg::t_value sibling [0:LEVELS-1];

    logic              r_in_valid;
    aoxrt_pkg::t_idx   r_in_idx;
    aoxrt_pkg::t_value r_in_value;

    logic              r_clearing;
    aoxrt_pkg::t_idx   r_clr_cnt;

    logic              r_head_valid;
    aoxrt_pkg::t_value r_head_value;
    logic              r_skid_valid;
    aoxrt_pkg::t_value r_skid_value;
    logic              n_head_valid;
    aoxrt_pkg::t_value n_head_value;
    logic              n_skid_valid;
    aoxrt_pkg::t_value n_skid_value;

    logic              chain_busy;
    logic              accept;
    logic              pop;
    logic [1:0]        held;
    aoxrt_pkg::t_idx   acc_idx;

    assign acc_idx = aoxrt_pkg::t_idx'(i_leaf_index);

    // Any update still climbing the tree blocks a new one.
    always_comb begin
        chain_busy = r_in_valid;
        for (int k = 1; k < LEVELS; k++) begin
            chain_busy = chain_busy | hop[k].valid;
        end
    end

    // Room for one more result counting those waiting and the one arriving.
    assign held    = 2'(r_head_valid) + 2'(r_skid_valid) + 2'(hop[LEVELS].valid);
    assign o_ready = !r_clearing && !chain_busy && (held < 2'd2);
    assign accept  = i_valid && o_ready;

    // Input register feeding the leaf cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_idx   <= acc_idx;
            r_in_value <= aoxrt_pkg::t_value'(i_leaf_value);
        end
    end

    assign hop[0].valid = r_in_valid;
    assign hop[0].idx   = r_in_idx;
    assign hop[0].value = r_in_value;

    // Clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == {LEVELS{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // One memory and one cell per level; level k holds nodes at height k.
    // Sibling reads are all issued at accept, since no sibling lies on the path.
    for (genvar k = 0; k < LEVELS; k++) begin : g_level
        localparam int AW = LEVELS - k;

        aoxrt_pkg::t_idx   shifted;
        logic [AW-1:0]     raddr;
        logic [AW-1:0]     waddr;
        logic              we;
        aoxrt_pkg::t_value wdata;

        assign shifted = acc_idx >> k;
        assign raddr   = shifted[AW-1:0] ^ AW'(1);
        assign we      = r_clearing || hop[k].valid;
        assign waddr   = r_clearing ? r_clr_cnt[AW-1:0] : hop[k].idx[AW-1:0];
        assign wdata   = r_clearing ? '0 : hop[k].value;

        aoxrt_ram #(
            .ADDR_W (AW),
            .DATA_W (aoxrt_pkg::VALUE_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (accept),
            .i_raddr (raddr),
            .o_rdata (sibling[k])
        );

        aoxrt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_is_or   ((k % 2 == 0) ? 1'b1 : 1'b0),
            .i_hop     (hop[k]),
            .i_sibling (sibling[k]),
            .o_hop     (hop[k+1])
        );
    end

    // Two-entry output queue: head drives the port, skid catches a second root.
    assign pop = r_head_valid && i_ready;

    always_comb begin
        n_head_valid = r_head_valid;
        n_head_value = r_head_value;
        n_skid_valid = r_skid_valid;
        n_skid_value = r_skid_value;
        if (!r_head_valid || pop) begin
            if (r_skid_valid) begin
                n_head_valid = 1'b1;
                n_head_value = r_skid_value;
                n_skid_valid = hop[LEVELS].valid;
                n_skid_value = hop[LEVELS].value;
            end else begin
                n_head_valid = hop[LEVELS].valid;
                n_head_value = hop[LEVELS].value;
            end
        end else if (hop[LEVELS].valid) begin
            n_skid_valid = 1'b1;
            n_skid_value = hop[LEVELS].value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_value <= n_head_value;
        r_skid_value <= n_skid_value;
    end

    assign o_valid      = r_head_valid;
    assign o_root_value = aoxrt_pkg::ROOT_W'(r_head_value);

endmodule

### dv/tb_alternating_or_xor_reduction_tree.sv
// Self-checking testbench for the alternating OR/XOR reduction tree.
`timescale 1ns / 100ps

module tb_alternating_or_xor_reduction_tree;

    // Drain wait for the end of the run, derived from the tree depth with a margin added.
    localparam int ROOT_LATENCY = aoxrt_pkg::LEVELS + 1;
    localparam int DRAIN_CYCLES = ROOT_LATENCY + 8;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int PHASE_WORDS  = 275;
    localparam int DIR_ROWS     = 23;

    // One directed write; has_root marks rows whose root is typed in.
    typedef struct packed {
        logic [aoxrt_pkg::INDEX_W-1:0] idx;
        logic [aoxrt_pkg::ROOT_W-1:0]  value;
        logic                          has_root;
        logic [aoxrt_pkg::ROOT_W-1:0]  root;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [aoxrt_pkg::INDEX_W-1:0] i_leaf_index;
    logic [aoxrt_pkg::ROOT_W-1:0]  i_leaf_value;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [aoxrt_pkg::ROOT_W-1:0]  o_root_value;

    // Shadow copy of the heap-ordered tree: root at 1, leaves from LEAF_COUNT.
    aoxrt_pkg::t_value tree_shadow [1:2*aoxrt_pkg::LEAF_COUNT-1];
    logic [aoxrt_pkg::ROOT_W-1:0] pending_roots [$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // State of the random index generator.
    logic [aoxrt_pkg::INDEX_W-1:0] cluster_base;
    logic [aoxrt_pkg::INDEX_W-1:0] sweep_ptr;
    logic [aoxrt_pkg::INDEX_W-1:0] last_idx;

    // A lone nonzero leaf passes unchanged to the root, so the first rows are
    // typed in; the rest are predicted. The index field is exactly as wide as
    // the tree, so every leaf is reachable and none wraps.
    t_dir_row dir_table [DIR_ROWS] = '{
        '{10'd0,    32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{10'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{10'd1023, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{10'd1023, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{10'd0,    32'h0000_0001, 1'b0, 32'h0},
        '{10'd1,    32'h8000_0000, 1'b0, 32'h0},
        '{10'd2,    32'h0000_FFFF, 1'b0, 32'h0},
        '{10'd3,    32'hFFFF_0000, 1'b0, 32'h0},
        '{10'd1,    32'h0000_0001, 1'b0, 32'h0},
        '{10'd1023, 32'hA5A5_A5A5, 1'b0, 32'h0},
        '{10'd1022, 32'h5A5A_5A5A, 1'b0, 32'h0},
        '{10'd1021, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{10'd1020, 32'h0F0F_0F0F, 1'b0, 32'h0},
        '{10'd511,  32'hFFFF_FFFF, 1'b0, 32'h0},
        '{10'd512,  32'hFFFF_FFFF, 1'b0, 32'h0},
        '{10'd256,  32'h1234_5678, 1'b0, 32'h0},
        '{10'd768,  32'h8765_4321, 1'b0, 32'h0},
        '{10'd4,    32'hAAAA_AAAA, 1'b0, 32'h0},
        '{10'd5,    32'h5555_5555, 1'b0, 32'h0},
        '{10'd6,    32'hFFFF_FFFF, 1'b0, 32'h0},
        '{10'd7,    32'hFFFF_FFFF, 1'b0, 32'h0},
        '{10'd512,  32'h0000_0000, 1'b0, 32'h0},
        '{10'd511,  32'h0000_0000, 1'b0, 32'h0}
    };

    alternating_or_xor_reduction_tree dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_leaf_index (i_leaf_index),
        .i_leaf_value (i_leaf_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_root_value (o_root_value)
    );

    // Free-running clock, 10 ns period.
    always #5 i_clk = ~i_clk;

    // Write one leaf in the shadow tree, rebuild its path and return the root.
    function automatic logic [aoxrt_pkg::ROOT_W-1:0] write_leaf_root(
        aoxrt_pkg::t_idx idx, aoxrt_pkg::t_value val);
        int unsigned node;
        int unsigned height;
        node   = aoxrt_pkg::LEAF_COUNT + idx;
        height = 0;
        tree_shadow[node] = val;
        while (node > 1) begin
            node   = node >> 1;
            height = height + 1;
            if (height % 2 == 1) begin
                tree_shadow[node] = tree_shadow[2*node] | tree_shadow[2*node+1];
            end else begin
                tree_shadow[node] = tree_shadow[2*node] ^ tree_shadow[2*node+1];
            end
        end
        return tree_shadow[1];
    endfunction

    // Offer one word after a random idle gap and hold it until accepted.
    task automatic send_word(input logic [aoxrt_pkg::INDEX_W-1:0] idx,
                             input logic [aoxrt_pkg::ROOT_W-1:0] val,
                             input logic has_root,
                             input logic [aoxrt_pkg::ROOT_W-1:0] root);
        logic [aoxrt_pkg::ROOT_W-1:0] predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_leaf_index <= idx;
        i_leaf_value <= val;
        do @(posedge i_clk); while (!o_ready);
        predicted = write_leaf_root(idx, val);
        pending_roots.push_back(has_root ? root : predicted);
    endtask

    // Stop sending and wait until every root word has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_roots.size() != 0) @(negedge i_clk);
    endtask

    // Random writes: scattered leaves mixed with clusters of neighbors,
    // sweeps and rewrites of the same leaf so that sibling paths interact.
    task automatic send_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned words);
        logic [aoxrt_pkg::INDEX_W-1:0] idx;
        logic [aoxrt_pkg::ROOT_W-1:0]  val;
        int unsigned                   pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int unsigned n = 0; n < words; n++) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
                idx = aoxrt_pkg::INDEX_W'($urandom_range(0, aoxrt_pkg::LEAF_COUNT - 1));
            end else if (pick <= 6) begin
                if ($urandom_range(0, 15) == 0) begin
                    cluster_base =
                        aoxrt_pkg::INDEX_W'($urandom_range(0, aoxrt_pkg::LEAF_COUNT - 1));
                end
                idx = {cluster_base[aoxrt_pkg::INDEX_W-1:3], 3'($urandom_range(0, 7))};
            end else if (pick <= 8) begin
                idx       = sweep_ptr;
                sweep_ptr = sweep_ptr + 1'b1;
            end else begin
                idx = last_idx;
            end
            last_idx = idx;
            case ($urandom_range(0, 7))
                0: val = '0;
                1: val = '1;
                2: val = aoxrt_pkg::ROOT_W'(1) << $urandom_range(0, aoxrt_pkg::ROOT_W - 1);
                3: val = ~(aoxrt_pkg::ROOT_W'(1) << $urandom_range(0, aoxrt_pkg::ROOT_W - 1));
                default: val = $urandom;
            endcase
            send_word(idx, val, 1'b0, '0);
        end
        wait_drained();
    endtask

    // Receiver readiness, redrawn every cycle.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare every accepted root word with the oldest expectation.
    always @(posedge i_clk) begin
        logic [aoxrt_pkg::ROOT_W-1:0] expected;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_roots.size() == 0) begin
                $display("%0t: root word %h arrived with no write pending", $time, o_root_value);
                mismatch_count++;
            end else begin
                expected = pending_roots.pop_front();
                if (o_root_value !== expected) begin
                    $display("%0t: root mismatch, expected %h, actual %h",
                             $time, expected, o_root_value);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases with sender gaps and receiver stalls.
    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_leaf_index = '0;
        i_leaf_value = '0;
        cluster_base = aoxrt_pkg::INDEX_W'($urandom_range(0, aoxrt_pkg::LEAF_COUNT - 1));
        sweep_ptr    = '0;
        last_idx     = '0;
        foreach (tree_shadow[n]) tree_shadow[n] = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words are offered with no idle gaps; the drain after them is the pause.
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_word(dir_table[r].idx, dir_table[r].value,
                      dir_table[r].has_root, dir_table[r].root);
        end
        wait_drained();

        send_random_phase(0, 0, PHASE_WORDS);
        send_random_phase(53, 0, PHASE_WORDS);
        send_random_phase(0, 53, PHASE_WORDS);
        send_random_phase(22, 22, PHASE_WORDS);

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_roots.size() == 0) begin
            $display("tb_alternating_or_xor_reduction_tree passed");
        end else begin
            $display("tb_alternating_or_xor_reduction_tree failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: timeout with %0d root words outstanding", $time, pending_roots.size());
        $display("tb_alternating_or_xor_reduction_tree failed");
        $finish;
    end

endmodule
